FILE: rtl/core/tmsa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and widths of the trimmed-mean sample averager.
package tmsa_pkg;

	localparam int CHANNELS          = 8;
	localparam int SAMPLES_PER_BLOCK = 16;
	localparam int TRIM_COUNT        = 2;

	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 12;
	localparam int AVG_W    = 16;
	localparam int FRAC_W   = 4;

	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W  = $clog2(SAMPLES_PER_BLOCK);
	localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLES_PER_BLOCK);
	localparam int X_W    = SUM_W + FRAC_W;

	localparam int DIVISOR = (SAMPLES_PER_BLOCK > TRIM_COUNT) ?
		(SAMPLES_PER_BLOCK - TRIM_COUNT) : 1;
	localparam int RECIP_W = X_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((longint'(1) << X_W) / longint'(DIVISOR));

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W      = FIFO_CNT_W + 1;

	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] max;
		logic [SAMPLE_W-1:0] min;
		logic [CNT_W-1:0]    count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                valid;
		logic [CH_W-1:0]     ch;
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] max;
		logic [SAMPLE_W-1:0] min;
	} acc_res_t;

	typedef struct packed {
		logic             valid;
		logic [CH_W-1:0]  ch;
		logic [AVG_W-1:0] avg;
	} div_res_t;

endpackage

FILE: rtl/core/tmsa_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
module tmsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tmsa_accum.sv
`timescale 1ns / 1ps
// Per-channel accumulator: channel RAM read-modify-write with a write-back bypass.
module tmsa_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [tmsa_pkg::CH_W-1:0]     channel,
	input  logic [tmsa_pkg::SAMPLE_W-1:0] sample,
	output logic                          busy,
	output tmsa_pkg::acc_res_t            res
);

	logic                              vld_s1;
	logic [tmsa_pkg::ADDR_W-1:0]       addr_s1;
	logic [tmsa_pkg::CH_W-1:0]         ch_s1;
	logic [tmsa_pkg::SAMPLE_W-1:0]     sample_s1;
	logic                              bp_v_q;
	logic [tmsa_pkg::ADDR_W-1:0]       bp_addr_q;
	tmsa_pkg::entry_t                  bp_entry_q;
	logic [tmsa_pkg::CHANNELS-1:0]     written_q;
	logic [tmsa_pkg::ENTRY_W-1:0]      rdata;
	tmsa_pkg::entry_t                  cur;
	tmsa_pkg::entry_t                  upd;
	tmsa_pkg::entry_t                  wentry;
	logic                              first;
	logic [tmsa_pkg::CNT_W:0]          nxt;
	logic                              done;
	logic                              in_range;

	assign in_range = (32'(channel) < tmsa_pkg::CHANNELS);

	tmsa_ram #(
		.WIDTH(tmsa_pkg::ENTRY_W),
		.DEPTH(tmsa_pkg::CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(addr_s1),
		.wdata(wentry),
		.re   (accept),
		.raddr(tmsa_pkg::ADDR_W'(channel)),
		.rdata(rdata)
	);

	always_comb begin
		if (bp_v_q && (bp_addr_q == addr_s1)) begin
			cur = bp_entry_q;
		end else if (written_q[addr_s1]) begin
			cur = tmsa_pkg::entry_t'(rdata);
		end else begin
			cur = '0;
		end
		first     = (cur.count == '0);
		upd.sum   = cur.sum + tmsa_pkg::SUM_W'(sample_s1);
		upd.max   = (first || (sample_s1 > cur.max)) ? sample_s1 : cur.max;
		upd.min   = (first || (sample_s1 < cur.min)) ? sample_s1 : cur.min;
		nxt       = {1'b0, cur.count} + 1'b1;
		upd.count = nxt[tmsa_pkg::CNT_W-1:0];
		done      = (nxt == (tmsa_pkg::CNT_W + 1)'(tmsa_pkg::SAMPLES_PER_BLOCK));
		wentry    = done ? '0 : upd;
	end

	assign res.valid = vld_s1 && done;
	assign res.ch    = ch_s1;
	assign res.sum   = upd.sum;
	assign res.max   = upd.max;
	assign res.min   = upd.min;
	assign busy      = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			bp_v_q    <= 1'b0;
			written_q <= '0;
		end else begin
			vld_s1 <= accept && in_range;
			bp_v_q <= vld_s1;
			if (vld_s1) begin
				written_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= tmsa_pkg::ADDR_W'(channel);
			ch_s1     <= channel;
			sample_s1 <= sample;
		end
		bp_addr_q  <= addr_s1;
		bp_entry_q <= wentry;
	end

endmodule

FILE: rtl/core/tmsa_divider.sv
`timescale 1ns / 1ps
// Trim and constant-divisor division pipeline: reciprocal multiply, then one correction.
module tmsa_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  tmsa_pkg::acc_res_t acc,
	output logic [1:0]         pending,
	output tmsa_pkg::div_res_t res
);

	localparam int PROD_W = 2 * tmsa_pkg::X_W + 1;
	localparam logic [tmsa_pkg::X_W-1:0] DIV_X = tmsa_pkg::X_W'(tmsa_pkg::DIVISOR);

	logic                          v_s2;
	logic [tmsa_pkg::CH_W-1:0]     ch_s2;
	logic [tmsa_pkg::SUM_W-1:0]    sum_s2;
	logic [tmsa_pkg::SAMPLE_W-1:0] max_s2;
	logic [tmsa_pkg::SAMPLE_W-1:0] min_s2;
	logic                          v_s3;
	logic [tmsa_pkg::CH_W-1:0]     ch_s3;
	logic [tmsa_pkg::X_W-1:0]      x_s3;
	logic                          v_s4;
	logic [tmsa_pkg::CH_W-1:0]     ch_s4;
	logic [tmsa_pkg::X_W-1:0]      x_s4;
	logic [tmsa_pkg::X_W-1:0]      q_s4;
	logic [tmsa_pkg::SUM_W-1:0]    mm;
	logic [tmsa_pkg::SUM_W-1:0]    trimmed;
	logic [tmsa_pkg::X_W-1:0]      x;
	logic [PROD_W-1:0]             prod;
	logic [tmsa_pkg::X_W-1:0]      qd;
	logic [tmsa_pkg::X_W-1:0]      rem;
	logic [tmsa_pkg::X_W-1:0]      q1;

	assign mm      = tmsa_pkg::SUM_W'(max_s2) + tmsa_pkg::SUM_W'(min_s2);
	assign trimmed = (sum_s2 >= mm) ? (sum_s2 - mm) : '0;
	assign x       = {trimmed, tmsa_pkg::FRAC_W'(0)};

	assign prod = PROD_W'(x_s3) * PROD_W'(tmsa_pkg::RECIP);

	assign qd  = tmsa_pkg::X_W'(q_s4 * DIV_X);
	assign rem = x_s4 - qd;
	assign q1  = q_s4 + tmsa_pkg::X_W'(rem >= DIV_X);

	assign res.valid = v_s4;
	assign res.ch    = ch_s4;
	assign res.avg   = (q1 > tmsa_pkg::X_W'({tmsa_pkg::AVG_W{1'b1}})) ?
		{tmsa_pkg::AVG_W{1'b1}} : q1[tmsa_pkg::AVG_W-1:0];

	assign pending = {1'b0, v_s2} + {1'b0, v_s3} + {1'b0, v_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= acc.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ch_s2  <= acc.ch;
		sum_s2 <= acc.sum;
		max_s2 <= acc.max;
		min_s2 <= acc.min;
		ch_s3  <= ch_s2;
		x_s3   <= x;
		ch_s4  <= ch_s3;
		x_s4   <= x_s3;
		q_s4   <= prod[2*tmsa_pkg::X_W-1:tmsa_pkg::X_W];
	end

endmodule

FILE: rtl/core/tmsa_out_fifo.sv
`timescale 1ns / 1ps
// Result queue that decouples the division pipeline from the result channel.
module tmsa_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tmsa_pkg::div_res_t                push,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic [tmsa_pkg::CH_W-1:0]         out_channel,
	output logic [tmsa_pkg::AVG_W-1:0]        average_q4,
	output logic [tmsa_pkg::FIFO_CNT_W-1:0]   count
);

	logic [tmsa_pkg::CH_W-1:0]       ch_q  [tmsa_pkg::FIFO_DEPTH];
	logic [tmsa_pkg::AVG_W-1:0]      avg_q [tmsa_pkg::FIFO_DEPTH];
	logic [tmsa_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [tmsa_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [tmsa_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                            pop;

	assign result_valid = (cnt_q != '0);
	assign out_channel  = ch_q[rd_ptr_q];
	assign average_q4   = avg_q[rd_ptr_q];
	assign count        = cnt_q;
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			ch_q[wr_ptr_q]  <= push.ch;
			avg_q[wr_ptr_q] <= push.avg;
		end
	end

endmodule

FILE: rtl/core/trimmed_mean_sample_averager_top.sv
`timescale 1ns / 1ps
// Top level of the trimmed-mean sample averager.
// The block takes one sample request per clock cycle while sample_stall is low. Each request
// reads its channel's entry from a RAM with a registered read port, updates sum, maximum,
// minimum and count, and writes it back in the next cycle; a one-entry bypass covers
// back-to-back requests to the same channel. The sustained rate is therefore one sample per
// cycle when not stalled, set by that read-modify-write loop. When a channel's block completes,
// the trimmed mean leaves on the result channel through a reciprocal-multiply divider and an
// eight-entry result queue. sample_stall rises only when the queued results, the results inside
// the divider and the sample in the accumulate stage together reach eight.
// There is no clearing pass after reset: per-channel valid bits make unwritten entries read
// as empty.
module trimmed_mean_sample_averager_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [tmsa_pkg::CH_W-1:0]     channel,
	input  logic [tmsa_pkg::SAMPLE_W-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [tmsa_pkg::CH_W-1:0]     out_channel,
	output logic [tmsa_pkg::AVG_W-1:0]    average_q4
);

	logic                            accept;
	logic                            busy;
	logic [1:0]                      pending;
	logic [tmsa_pkg::FIFO_CNT_W-1:0] fifo_cnt;
	logic [tmsa_pkg::OCC_W-1:0]      occupancy;
	tmsa_pkg::acc_res_t              acc_res;
	tmsa_pkg::div_res_t              div_res;

	assign occupancy = tmsa_pkg::OCC_W'(fifo_cnt) + tmsa_pkg::OCC_W'(pending) +
		tmsa_pkg::OCC_W'(busy);
	assign sample_stall = (occupancy >= tmsa_pkg::OCC_W'(tmsa_pkg::FIFO_DEPTH));
	assign accept       = sample_valid && !sample_stall;

	tmsa_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.channel(channel),
		.sample (sample),
		.busy   (busy),
		.res    (acc_res)
	);

	tmsa_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_res),
		.pending(pending),
		.res    (div_res)
	);

	tmsa_out_fifo u_out_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (div_res),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.out_channel (out_channel),
		.average_q4  (average_q4),
		.count       (fifo_cnt)
	);

endmodule

FILE: rtl/core/tmsa_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the trimmed-mean sample averager and its bind statement.
module tmsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [tmsa_pkg::CH_W-1:0]     out_channel,
	input logic [tmsa_pkg::AVG_W-1:0]    average_q4
);

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(out_channel) && $stable(average_q4))
		else $error("Result changed while stalled.");

	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (average_q4 <= 16'd65520))
		else $error("Average exceeds the largest possible trimmed mean.");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !result_valid && !sample_stall)
		else $error("Block is not idle after reset.");

	a_stall_needs_results: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("Sample side stalled with no result waiting.");

endmodule

bind trimmed_mean_sample_averager_top tmsa_checker u_tmsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.out_channel (out_channel),
	.average_q4  (average_q4)
);
